/* rtl/core/tea_variant_block_cipher_unit_defines.svh */
// Assertion macros shared by the cipher RTL.
// No dependencies; included by files that carry assertions.
`ifndef TEA_VARIANT_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define TEA_VARIANT_BLOCK_CIPHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TEA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// next-cycle implication
`define TEA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define TEA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TEA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/tea_pkg.sv */
// Shared types, constants and half-round mix functions for the cipher.
// No dependencies.
package tea_pkg;

   localparam int unsigned WordWidth     = 32;
   localparam int unsigned RoundWidth    = 7;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [WordWidth-1:0]  TEA_DELTA    = 32'h9e3779b9;
   localparam logic [RoundWidth-1:0] ROUNDS_RESET = 7'd32;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY0   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY1   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY2   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY3   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ROUNDS = 3'd4;

   typedef logic [WordWidth-1:0] tea_word_type;

   typedef struct packed {
      tea_word_type k0;
      tea_word_type k1;
      tea_word_type k2;
      tea_word_type k3;
   } tea_key_type;

   typedef struct packed {
      tea_key_type           key;
      logic [RoundWidth-1:0] rounds;
   } tea_cfg_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } tea_state_type;

   function automatic tea_word_type mix_first(tea_word_type x, tea_word_type s,
                                              tea_key_type k);
      return ((x << 4) + k.k0) ^ (x + s) ^ ((x >> 5) + k.k1);
   endfunction

   // variant: key word 2 is XORed, not added
   function automatic tea_word_type mix_second(tea_word_type x, tea_word_type s,
                                               tea_key_type k);
      return ((x << 4) ^ k.k2) ^ (x + s) ^ ((x >> 5) + k.k3);
   endfunction

endpackage

/* rtl/core/tea_req_if.sv */
// Request channel: valid/ready plus one input block and the operation select.
// Depends on tea_pkg.
interface tea_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   tea_pkg::tea_word_type block_lo;
   tea_pkg::tea_word_type block_hi;

   modport source (output valid, func, block_lo, block_hi, input ready);
   modport sink   (input valid, func, block_lo, block_hi, output ready);
endinterface

/* rtl/core/tea_rsp_if.sv */
// Response channel: valid/ready plus one result block.
// Depends on tea_pkg.
interface tea_rsp_if;
   logic                 valid;
   logic                 ready;
   tea_pkg::tea_word_type result_lo;
   tea_pkg::tea_word_type result_hi;

   modport source (output valid, result_lo, result_hi, input ready);
   modport sink   (input valid, result_lo, result_hi, output ready);
endinterface

/* rtl/core/tea_round.sv */
// Shared round unit: one full Feistel round (two half-rounds), either direction.
// Depends on tea_pkg.
module tea_round (
   input  logic                  decrypt,
   input  tea_pkg::tea_word_type v0,
   input  tea_pkg::tea_word_type v1,
   input  tea_pkg::tea_word_type sum,
   input  tea_pkg::tea_key_type  key,
   output tea_pkg::tea_word_type v0_out,
   output tea_pkg::tea_word_type v1_out
);
   import tea_pkg::*;

   tea_word_type enc_v0;
   tea_word_type dec_v1;

   assign enc_v0 = v0 + mix_first(v1, sum, key);
   assign dec_v1 = v1 - mix_second(v0, sum, key);

   always_comb begin
      if (decrypt) begin
         v1_out = dec_v1;
         v0_out = v0 - mix_first(dec_v1, sum, key);
      end else begin
         v0_out = enc_v0;
         v1_out = v1 + mix_second(enc_v0, sum, key);
      end
   end
endmodule

/* rtl/core/tea_seq.sv */
// Round sequencer: block and sum registers, round counter, output register.
// Depends on tea_pkg, tea_req_if, tea_rsp_if, tea_round and the defines header.
`include "tea_variant_block_cipher_unit_defines.svh"

module tea_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  tea_pkg::tea_cfg_type cfg,
   tea_req_if.sink              req_ch,
   tea_rsp_if.source            rsp_ch
);
   import tea_pkg::*;

   tea_state_type         state_ff, state_in;
   logic [RoundWidth-1:0] cnt_ff, cnt_in;
   tea_word_type          sum_ff, sum_in;
   logic                  dec_ff, dec_in;
   tea_word_type          v0_ff, v0_in, v1_ff, v1_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tea_word_type          res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;

   tea_word_type start_sum;
   tea_word_type r_v0, r_v1;
   logic         out_free;
   logic         out_load;

   // decrypt starts at rounds * delta mod 2^32
   assign start_sum = {{(WordWidth-RoundWidth){1'b0}}, cfg.rounds} * TEA_DELTA;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   tea_round u_round (
      .decrypt (dec_ff),
      .v0      (v0_ff),
      .v1      (v1_ff),
      .sum     (sum_ff),
      .key     (cfg.key),
      .v0_out  (r_v0),
      .v1_out  (r_v1)
   );

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result_lo = res_lo_ff;
   assign rsp_ch.result_hi = res_hi_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      dec_in       = dec_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      res_lo_in    = res_lo_ff;
      res_hi_in    = res_hi_ff;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               dec_in = req_ch.func;
               v0_in  = req_ch.block_lo;
               v1_in  = req_ch.block_hi;
               cnt_in = cfg.rounds;
               sum_in = req_ch.func ? start_sum : TEA_DELTA;
               state_in = (cfg.rounds == '0) ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            if (cnt_ff == RoundWidth'(1)) begin
               // last round goes straight to the output register
               if (out_free) begin
                  out_load  = 1'b1;
                  res_lo_in = r_v0;
                  res_hi_in = r_v1;
                  state_in  = S_IDLE;
               end
            end else begin
               v0_in  = r_v0;
               v1_in  = r_v1;
               sum_in = dec_ff ? (sum_ff - TEA_DELTA) : (sum_ff + TEA_DELTA);
               cnt_in = cnt_ff - RoundWidth'(1);
            end
         end
         S_DONE: begin
            // zero rounds: item passes through unchanged
            if (out_free) begin
               out_load  = 1'b1;
               res_lo_in = v0_ff;
               res_hi_in = v1_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      dec_ff    <= dec_in;
      v0_ff     <= v0_in;
      v1_ff     <= v1_in;
      res_lo_ff <= res_lo_in;
      res_hi_ff <= res_hi_in;
   end

   `TEA_ASSERT_NEXT(a_start_run, clock, reset, req_ch.valid && req_ch.ready && cfg.rounds != '0, state_ff == S_RUN && cnt_ff == $past(cfg.rounds))
   `TEA_ASSERT_NOW(a_run_cnt_nonzero, clock, reset, state_ff == S_RUN, cnt_ff != '0)
   `TEA_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid_ff), $past(state_ff) != S_IDLE)
   `TEA_ASSERT_NEXT(a_load_then_idle, clock, reset, out_load, state_ff == S_IDLE && rsp_valid_ff)
endmodule

/* rtl/core/tea_variant_block_cipher_unit.sv */
// Top level of the TEA-variant block cipher: register file and round sequencer.
// Depends on tea_pkg, tea_req_if, tea_rsp_if and tea_seq.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    func, block_lo, block_hi
//   rsp_ch    out   valid / ready    result_lo, result_hi
//   csr_*     in    csr_we           csr_index, csr_wdata (no read-back)
//
// An item runs from accept to the result register one round per cycle in the
// shared round unit, holding at the final round while the output register is
// full; a count of zero passes the item through unchanged.
// Reset is synchronous: keys clear to zero, round_count returns to 32.
// req_ch.ready is low while an item is in work; a stalled result holds
// the final round until the output register frees up.
module tea_variant_block_cipher_unit (
   input  logic                               clock,
   input  logic                               reset,
   tea_req_if.sink                            req_ch,
   tea_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [tea_pkg::CsrIndexWidth-1:0]  csr_index,
   input  tea_pkg::tea_word_type              csr_wdata
);
   import tea_pkg::*;

   tea_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY0:   cfg_in.key.k0 = csr_wdata;
            CSR_KEY1:   cfg_in.key.k1 = csr_wdata;
            CSR_KEY2:   cfg_in.key.k2 = csr_wdata;
            CSR_KEY3:   cfg_in.key.k3 = csr_wdata;
            CSR_ROUNDS: cfg_in.rounds = csr_wdata[RoundWidth-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key    <= '0;
         cfg_ff.rounds <= ROUNDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tea_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );
endmodule

/* sim/tea_variant_block_cipher_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for tea_variant_block_cipher_unit: a directed table, then random phases.
// Each phase may set keys and sets the round count; items are checked against a local cipher model.
// Depends on tea_pkg, tea_req_if, tea_rsp_if and the cipher RTL.
module tea_variant_block_cipher_unit_test;
   import tea_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned TABLE_ROWS   = 33;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_LAST  = 3'd7;
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef struct packed {
      tea_word_type lo;
      tea_word_type hi;
   } cipher_words_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // CSR rows: lo_or_index holds the register index, hi_or_data the write data
   typedef struct packed {
      row_kind_type kind;
      logic         func;
      tea_word_type lo_or_index;
      tea_word_type hi_or_data;
      logic         given;
      tea_word_type want_lo;
      tea_word_type want_hi;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   tea_word_type csr_wdata;

   tea_req_if req_ch ();
   tea_rsp_if rsp_ch ();

   tea_variant_block_cipher_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // local copy of the key and round registers
   tea_word_type            key_words [4] = '{default: '0};
   logic [RoundWidth-1:0]   round_setting = ROUNDS_RESET;

   cipher_words_type awaited_blocks [$];
   int  error_count  = 0;
   int  quiet_cycles = 0;
   bit  send_idling  = 1'b1;
   bit  rsp_idling   = 1'b1;
   bit  hold_request = 1'b0;

   stim_row_type stim_table [TABLE_ROWS] = '{
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'hffffffff, 32'hffffffff, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'h00000000, 32'h00000000, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'hffffffff, 32'hffffffff, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h80000000, 32'h00000001, 1'b0, '0, '0},
      // zero rounds pass the block through unchanged
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_ROUNDS), 32'h00000000, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h12345678, 32'h9abcdef0, 1'b1, 32'h12345678, 32'h9abcdef0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff, 32'h00000000},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_KEY0), 32'hffffffff, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_KEY1), 32'hffffffff, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_KEY2), 32'hffffffff, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_KEY3), 32'hffffffff, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_ROUNDS), 32'h00000001, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'hffffffff, 32'hffffffff, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h00000001, 32'h80000000, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_ROUNDS), 32'h00000040, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h00000000, 32'hffffffff, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'h00000000, 32'hffffffff, 1'b0, '0, '0},
      // round counts past 64 run exactly that many rounds
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_ROUNDS), 32'h0000007f, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0, '0, '0},
      // upper data bits are dropped: count becomes 65
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_ROUNDS), 32'hffffffc1, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, '0, '0},
      // writes past the register list must change nothing
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_SPARE_FIRST), 32'h00000000, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_SPARE_LAST), 32'h00000003, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_SPARE_LAST), 32'hffffffff, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_KEY2), 32'h80000000, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_KEY0), 32'h00000000, 1'b0, '0, '0},
      '{ROW_CSR,  FUNC_ENCRYPT, 32'(CSR_ROUNDS), 32'h00000020, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_ENCRYPT, 32'hdeadbeef, 32'h01234567, 1'b0, '0, '0},
      '{ROW_ITEM, FUNC_DECRYPT, 32'hdeadbeef, 32'h01234567, 1'b0, '0, '0}
   };

   function automatic tea_word_type key01_mix(tea_word_type x, tea_word_type s);
      return ((x << 4) + key_words[0]) ^ (x + s) ^ ((x >> 5) + key_words[1]);
   endfunction

   // key word 2 is XORed in this variant
   function automatic tea_word_type key23_mix(tea_word_type x, tea_word_type s);
      return ((x << 4) ^ key_words[2]) ^ (x + s) ^ ((x >> 5) + key_words[3]);
   endfunction

   function automatic cipher_words_type tea_variant_rounds(logic op, tea_word_type lo,
                                                          tea_word_type hi);
      tea_word_type v0;
      tea_word_type v1;
      tea_word_type sum;
      int r;
      v0 = lo;
      v1 = hi;
      if (op == FUNC_ENCRYPT) begin
         sum = '0;
         for (r = 0; r < int'(round_setting); r++) begin
            sum = sum + TEA_DELTA;
            v0  = v0 + key01_mix(v1, sum);
            v1  = v1 + key23_mix(v0, sum);
         end
      end else begin
         sum = TEA_DELTA * 32'(round_setting);
         for (r = 0; r < int'(round_setting); r++) begin
            v1  = v1 - key23_mix(v0, sum);
            v0  = v0 - key01_mix(v1, sum);
            sum = sum - TEA_DELTA;
         end
      end
      return '{lo: v0, hi: v1};
   endfunction

   function automatic tea_word_type random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [RoundWidth-1:0] pick_rounds();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return RoundWidth'($urandom_range(65, 127));
         3: return RoundWidth'(64);
         4: return RoundWidth'(1);
         default: return RoundWidth'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // drop valid first so the last item is not taken a second time
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (awaited_blocks.size() != 0) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it once the batch of writes is done
   task automatic write_csr(input logic [CsrIndexWidth-1:0] index, input tea_word_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_KEY0:   key_words[0] = value;
         CSR_KEY1:   key_words[1] = value;
         CSR_KEY2:   key_words[2] = value;
         CSR_KEY3:   key_words[3] = value;
         CSR_ROUNDS: round_setting = value[RoundWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic send_block(input logic op, input tea_word_type lo, input tea_word_type hi,
                             input logic given, input cipher_words_type given_value);
      if (send_idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= op;
      req_ch.block_lo <= lo;
      req_ch.block_hi <= hi;
      do @(posedge clock); while (!req_ch.ready);
      awaited_blocks.push_back(given ? given_value : tea_variant_rounds(op, lo, hi));
   endtask

   task automatic check_result();
      cipher_words_type want;
      if (awaited_blocks.size() == 0) begin
         report_mismatch($sformatf("result %h_%h with no block awaited",
                                   rsp_ch.result_hi, rsp_ch.result_lo));
      end else begin
         want = awaited_blocks.pop_front();
         if (rsp_ch.result_lo !== want.lo)
            report_mismatch($sformatf("result_lo %h, want %h", rsp_ch.result_lo, want.lo));
         if (rsp_ch.result_hi !== want.hi)
            report_mismatch($sformatf("result_hi %h, want %h", rsp_ch.result_hi, want.hi));
      end
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin : result_sink
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] watchdog: no item moved for %0d cycles", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : main_sequence
      stim_row_type     row;
      cipher_words_type last_cipher;
      bit               have_cipher;
      logic             op;
      tea_word_type     lo;
      tea_word_type     hi;
      tea_word_type     rounds_word;
      int               phase_count;
      int               random_sent;
      int               phase_items;
      int               i;

      phase_count = 0;
      random_sent = 0;
      have_cipher = 1'b0;
      last_cipher = '0;
      req_ch.valid    <= 1'b0;
      req_ch.func     <= FUNC_ENCRYPT;
      req_ch.block_lo <= '0;
      req_ch.block_hi <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_KEY0;
      csr_wdata       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) begin
         row = stim_table[k];
         if (row.kind == ROW_CSR) begin
            wait_drained();
            write_csr(row.lo_or_index[CsrIndexWidth-1:0], row.hi_or_data);
         end else begin
            csr_we <= 1'b0;
            send_block(row.func, row.lo_or_index, row.hi_or_data, row.given,
                       '{lo: row.want_lo, hi: row.want_hi});
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         phase_count++;
         // the tail of the run goes without idling on either side
         if (random_sent + 150 >= RANDOM_ITEMS) begin
            send_idling = 1'b0;
            rsp_idling  = 1'b0;
         end else begin
            send_idling = ($urandom_range(0, 3) != 0);
            rsp_idling  = ($urandom_range(0, 3) != 0);
         end
         wait_drained();
         if ($urandom_range(0, 2) != 0) write_csr(CSR_KEY0, random_word());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_KEY1, random_word());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_KEY2, random_word());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_KEY3, random_word());
         rounds_word = $urandom();
         rounds_word[RoundWidth-1:0] = pick_rounds();
         write_csr(CSR_ROUNDS, rounds_word);
         if ($urandom_range(0, 7) == 0)
            write_csr(CsrIndexWidth'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                      $urandom());
         csr_we <= 1'b0;
         have_cipher = 1'b0;
         if (phase_count == 3) hold_request = 1'b1;

         phase_items = $urandom_range(20, 60);
         for (i = 0; i < phase_items; i++) begin
            op = 1'($urandom_range(0, 1));
            // decrypt of a recent ciphertext now and then: a proper round trip
            if (op == FUNC_DECRYPT && have_cipher && $urandom_range(0, 2) == 0) begin
               lo = last_cipher.lo;
               hi = last_cipher.hi;
            end else begin
               lo = random_word();
               hi = random_word();
            end
            if (op == FUNC_ENCRYPT) begin
               last_cipher = tea_variant_rounds(op, lo, hi);
               have_cipher = 1'b1;
            end
            send_block(op, lo, hi, 1'b0, '0);
            random_sent++;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* tea_variant_block_cipher_unit.f */
+incdir+rtl/core
rtl/core/tea_pkg.sv
rtl/core/tea_req_if.sv
rtl/core/tea_rsp_if.sv
rtl/core/tea_round.sv
rtl/core/tea_seq.sv
rtl/core/tea_variant_block_cipher_unit.sv
sim/tea_variant_block_cipher_unit_test.sv
